// ===== sv/rrr_pkg.sv =====
// Shared constants, codes and types of the replica range remap block.
package rrr_pkg;

  // Table and map sizes
  localparam int MAX_WINDOWS = 64;
  localparam int NUM_CPUS    = 256;
  localparam int QUEUE_DEPTH = 2;

  // Field widths
  localparam int ADDR_W      = 48;
  localparam int CPU_W       = 8;
  localparam int NODE_W      = 6;
  localparam int REPL_NODE_W = 7;
  localparam int OP_W        = 2;
  localparam int STATUS_W    = 2;
  localparam int KIND_W      = 3;

  // Derived index and count widths
  localparam int WIN_IDX_W = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
  localparam int WIN_CNT_W = $clog2(MAX_WINDOWS + 1);
  localparam int CPU_IDX_W = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;

  // Operation codes
  localparam logic [OP_W-1:0] OP_TRANSLATE = 2'd0;
  localparam logic [OP_W-1:0] OP_REGISTER  = 2'd1;
  localparam logic [OP_W-1:0] OP_SET_NODE  = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BAD_WIN  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd2;

  // Item classes decided at the front
  localparam logic [KIND_W-1:0] KIND_NOP       = 3'd0;
  localparam logic [KIND_W-1:0] KIND_TRANSLATE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_PASS      = 3'd2;
  localparam logic [KIND_W-1:0] KIND_ADD       = 3'd3;
  localparam logic [KIND_W-1:0] KIND_BAD_WIN   = 3'd4;
  localparam logic [KIND_W-1:0] KIND_MAP       = 3'd5;

  // Classified item as held in the queue
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ADDR_W-1:0] address;
    logic [ADDR_W-1:0] window_size;
    logic [ADDR_W-1:0] replica_base;
    logic [CPU_W-1:0]  cpu;
    logic [NODE_W-1:0] cpu_node;
    logic              cpu_ok;
  } item_t;

  // One entry of the window table
  typedef struct packed {
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] length;
    logic [ADDR_W-1:0] replica;
  } window_t;

endpackage

// ===== sv/rrr_ifs.sv =====
// Valid/ready channel interfaces for requests and results.
interface rrr_in_if;
  import rrr_pkg::*;
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     op;
  logic [ADDR_W-1:0]   address;
  logic [ADDR_W-1:0]   window_size;
  logic [ADDR_W-1:0]   replica_base;
  logic [CPU_W-1:0]    cpu;
  logic [NODE_W-1:0]   cpu_node;

  modport source (output valid, op, address, window_size, replica_base, cpu, cpu_node,
                  input ready);
  modport sink   (input valid, op, address, window_size, replica_base, cpu, cpu_node,
                  output ready);
endinterface

interface rrr_out_if;
  import rrr_pkg::*;
  logic                valid;
  logic                ready;
  logic [ADDR_W-1:0]   out_address;
  logic                hit;
  logic [STATUS_W-1:0] status;

  modport source (output valid, out_address, hit, status, input ready);
  modport sink   (input valid, out_address, hit, status, output ready);
endinterface

// ===== sv/rrr_front.sv =====
// Front end: accept request items and classify them for the back end.
module rrr_front (
  rrr_in_if.sink         req,
  input  logic           q_ready,
  output logic           push,
  output rrr_pkg::item_t item
);
  import rrr_pkg::*;

  logic bad_window;

  // Take an item whenever the queue has room
  assign req.ready = q_ready;
  assign push      = req.valid;

  // A window with a zero base, size or replica is rejected
  assign bad_window = (req.address == '0) || (req.window_size == '0) ||
                      (req.replica_base == '0);

  // Classify the operation and carry the payload on
  always_comb begin
    item.address      = req.address;
    item.window_size  = req.window_size;
    item.replica_base = req.replica_base;
    item.cpu          = req.cpu;
    item.cpu_node     = req.cpu_node;
    item.cpu_ok       = (32'(req.cpu) < NUM_CPUS);
    case (req.op)
      OP_TRANSLATE: item.kind = (req.address == '0) ? KIND_PASS : KIND_TRANSLATE;
      OP_REGISTER:  item.kind = bad_window ? KIND_BAD_WIN : KIND_ADD;
      OP_SET_NODE:  item.kind = KIND_MAP;
      default:      item.kind = KIND_NOP;
    endcase
  end

endmodule

// ===== sv/rrr_queue.sv =====
// Short FIFO of classified items between front and back ends.
module rrr_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  rrr_pkg::item_t push_item,
  output logic           push_ready,
  input  logic           pop,
  output logic           pop_valid,
  output rrr_pkg::item_t pop_item
);
  import rrr_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t            slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (fill != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_item   = slots[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  // Store pushed items
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (32'(wr_ptr) == QUEUE_DEPTH - 1) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (32'(rd_ptr) == QUEUE_DEPTH - 1) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

  // Fill level stays within depth
  assert property (@(posedge clk) disable iff (rst) 32'(fill) <= QUEUE_DEPTH)
    else $error("queue fill level beyond depth");

endmodule

// ===== sv/rrr_back.sv =====
// Back end: node map, window table, serial window scan and result register.
module rrr_back (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                q_valid,
  input  rrr_pkg::item_t                      q_item,
  output logic                                q_pop,
  input  logic                                cfg_we,
  input  logic [rrr_pkg::REPL_NODE_W-1:0]     cfg_data,
  rrr_out_if.source                           rsp
);
  import rrr_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_NODE = 3'd1;
  localparam logic [2:0] ST_RD   = 3'd2;
  localparam logic [2:0] ST_CMP  = 3'd3;
  localparam logic [2:0] ST_ADD  = 3'd4;

  // Control state
  logic [2:0]             st;
  logic [2:0]             st_next;
  logic [WIN_CNT_W-1:0]   win_count;
  logic [REPL_NODE_W-1:0] replica_node;
  logic [NUM_CPUS-1:0]    node_vld;
  logic                   out_vld;

  // Memories
  window_t                win_mem  [MAX_WINDOWS];
  logic [NODE_W-1:0]      node_mem [NUM_CPUS];

  // Payload registers
  item_t                  cur;
  window_t                win_rd;
  logic [NODE_W-1:0]      node_rd;
  logic                   node_vld_rd;
  logic [WIN_IDX_W-1:0]   idx;
  logic [ADDR_W-1:0]      diff_r;
  logic [ADDR_W-1:0]      repl_r;
  logic                   match_r;
  logic [ADDR_W-1:0]      out_addr;
  logic                   out_hit;
  logic [STATUS_W-1:0]    out_status;

  // Decode
  logic                   pop;
  logic                   win_full;
  logic                   win_we;
  logic                   node_we;
  logic [NODE_W-1:0]      node_eff;
  logic                   node_match;
  logic [ADDR_W:0]        sub;
  logic                   in_win;
  logic                   last;
  logic                   fin;
  logic [ADDR_W-1:0]      fin_addr;
  logic                   fin_hit;
  logic [STATUS_W-1:0]    fin_status;

  assign pop        = q_valid && (st == ST_IDLE) && (!out_vld || rsp.ready);
  assign q_pop      = pop;
  assign win_full   = (win_count == WIN_CNT_W'(MAX_WINDOWS));
  assign win_we     = pop && (q_item.kind == KIND_ADD) && !win_full;
  assign node_we    = pop && (q_item.kind == KIND_MAP) && q_item.cpu_ok;
  assign node_eff   = (cur.cpu_ok && node_vld_rd) ? node_rd : '0;
  assign node_match = (replica_node == {1'b0, node_eff});
  assign sub        = {1'b0, cur.address} - {1'b0, win_rd.base};
  assign in_win     = !sub[ADDR_W] && (sub[ADDR_W-1:0] < win_rd.length);
  assign last       = ((WIN_CNT_W'(idx) + WIN_CNT_W'(1)) == win_count);

  // Sequence one item and pick its result
  always_comb begin
    st_next    = st;
    fin        = 1'b0;
    fin_addr   = '0;
    fin_hit    = 1'b0;
    fin_status = STATUS_OK;
    case (st)
      ST_IDLE: begin
        if (pop) begin
          case (q_item.kind)
            KIND_TRANSLATE: begin
              if ((win_count == '0) || replica_node[REPL_NODE_W-1]) begin
                fin      = 1'b1;
                fin_addr = q_item.address;
              end else begin
                st_next = ST_NODE;
              end
            end
            KIND_PASS: begin
              fin      = 1'b1;
              fin_addr = q_item.address;
            end
            KIND_BAD_WIN: begin
              fin        = 1'b1;
              fin_status = STATUS_BAD_WIN;
            end
            KIND_ADD: begin
              fin        = 1'b1;
              fin_status = win_full ? STATUS_FULL : STATUS_OK;
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      ST_NODE: begin
        if (node_match) begin
          st_next = ST_RD;
        end else begin
          fin      = 1'b1;
          fin_addr = cur.address;
        end
      end
      ST_RD:  st_next = ST_CMP;
      ST_CMP: st_next = ST_ADD;
      ST_ADD: begin
        if (match_r) begin
          fin      = 1'b1;
          fin_addr = repl_r + diff_r;
          fin_hit  = 1'b1;
        end else if (last) begin
          fin      = 1'b1;
          fin_addr = cur.address;
        end else begin
          st_next = ST_RD;
        end
      end
      default: st_next = ST_IDLE;
    endcase
    if (fin) begin
      st_next = ST_IDLE;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      st           <= ST_IDLE;
      win_count    <= '0;
      replica_node <= '1;
      node_vld     <= '0;
      out_vld      <= 1'b0;
    end else begin
      st <= st_next;
      if (cfg_we) begin
        replica_node <= cfg_data;
      end
      if (win_we) begin
        win_count <= win_count + WIN_CNT_W'(1);
      end
      if (node_we) begin
        node_vld[q_item.cpu[CPU_IDX_W-1:0]] <= 1'b1;
      end
      if (fin) begin
        out_vld <= 1'b1;
      end else if (rsp.ready) begin
        out_vld <= 1'b0;
      end
    end
  end

  // Window table: one write, one registered read
  always_ff @(posedge clk) begin
    if (win_we) begin
      win_mem[win_count[WIN_IDX_W-1:0]] <= '{base:    q_item.address,
                                             length:  q_item.window_size,
                                             replica: q_item.replica_base};
    end
    win_rd <= win_mem[idx];
  end

  // Node map: one write, one registered read with its valid bit
  always_ff @(posedge clk) begin
    if (node_we) begin
      node_mem[q_item.cpu[CPU_IDX_W-1:0]] <= q_item.cpu_node;
    end
    node_rd     <= node_mem[q_item.cpu[CPU_IDX_W-1:0]];
    node_vld_rd <= node_vld[q_item.cpu[CPU_IDX_W-1:0]];
  end

  // Payload registers of the scan and the result
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_item;
      idx <= '0;
    end else if ((st == ST_ADD) && !match_r && !last) begin
      idx <= idx + WIN_IDX_W'(1);
    end
    if (st == ST_CMP) begin
      diff_r  <= sub[ADDR_W-1:0];
      repl_r  <= win_rd.replica;
      match_r <= in_win;
    end
    if (fin) begin
      out_addr   <= fin_addr;
      out_hit    <= fin_hit;
      out_status <= fin_status;
    end
  end

  assign rsp.valid       = out_vld;
  assign rsp.out_address = out_addr;
  assign rsp.hit         = out_hit;
  assign rsp.status      = out_status;

  // The table never holds more than its size
  assert property (@(posedge clk) disable iff (rst) 32'(win_count) <= MAX_WINDOWS)
    else $error("window count beyond table size");

  // Scan reads only written entries
  assert property (@(posedge clk) disable iff (rst)
                   (st == ST_RD) |-> (WIN_CNT_W'(idx) < win_count))
    else $error("window scan beyond filled entries");

  // The result register is empty while an item is in progress
  assert property (@(posedge clk) disable iff (rst) (st != ST_IDLE) |-> !out_vld)
    else $error("result pending during item work");

  // A redirected address always reports success
  assert property (@(posedge clk) disable iff (rst)
                   (out_vld && out_hit) |-> (out_status == STATUS_OK))
    else $error("hit with failure status");

endmodule

// ===== sv/replica_range_remap.sv =====
// Top level of the replica range remap block.
// Items are taken into a two-entry queue in one cycle each while it has room, and carried
// out one at a time from the queue head; a result waits in an output register while
// further items are taken. Window registration, node map writes, rejected and unused
// operations and a translate with an empty table, a zero address or remapping disabled
// finish when popped; else the node map is read and each window tried (up to MAX_WINDOWS)
// passes read, compare and add of the serial scan of the single-read-port window table.
// Windows are matched first-registered first; the node map starts at node 0 for every cpu.
module replica_range_remap (
  input  logic                            clk,
  input  logic                            rst,
  rrr_in_if.sink                          req,
  rrr_out_if.source                       rsp,
  input  logic                            cfg_we,
  input  logic [rrr_pkg::REPL_NODE_W-1:0] cfg_data
);
  import rrr_pkg::*;

  logic  push;
  logic  q_ready;
  item_t front_item;
  logic  q_valid;
  logic  q_pop;
  item_t q_item;

  // Classify incoming items
  rrr_front u_front (
    .req     (req),
    .q_ready (q_ready),
    .push    (push),
    .item    (front_item)
  );

  // Decouple front and back
  rrr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (front_item),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_item   (q_item)
  );

  // Carry out items and drive results
  rrr_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .rsp      (rsp)
  );

endmodule

// ===== tb/rrr_checker.sv =====
// Checker for the replica range remap block: predicts every result and compares it.
module rrr_checker (
  input  logic                            clk,
  input  logic                            rst,
  rrr_in_if                               req,
  rrr_out_if                              rsp,
  input  logic                            cfg_we,
  input  logic [rrr_pkg::REPL_NODE_W-1:0] cfg_data,
  output int                              mismatches,
  output int                              outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import rrr_pkg::*;

  typedef struct packed {
    logic [ADDR_W-1:0]   address;
    logic                hit;
    logic [STATUS_W-1:0] status;
  } remap_result_t;

  // Own copy of the window table, node map and replica node
  logic [ADDR_W-1:0]             win_base [MAX_WINDOWS];
  logic [ADDR_W-1:0]             win_len  [MAX_WINDOWS];
  logic [ADDR_W-1:0]             win_repl [MAX_WINDOWS];
  int                            win_count;
  logic [NODE_W-1:0]             cpu_map  [NUM_CPUS];
  logic signed [REPL_NODE_W-1:0] remap_node;

  remap_result_t awaited_results [$];

  // Work out the result of one item and update the tables as the block does
  function automatic remap_result_t predict_remap(
    input logic [OP_W-1:0]   op,
    input logic [ADDR_W-1:0] addr,
    input logic [ADDR_W-1:0] size,
    input logic [ADDR_W-1:0] repl,
    input logic [CPU_W-1:0]  cpu,
    input logic [NODE_W-1:0] node
  );
    remap_result_t     r;
    logic [ADDR_W-1:0] offset;
    bit                found;
    r = '0;
    found = 0;
    case (op)
      OP_TRANSLATE: begin
        r.address = addr;
        // Remap only for a cpu on the enabled replica node, first window wins
        if (win_count != 0 && addr != 0 && !remap_node[REPL_NODE_W-1] &&
            {1'b0, cpu_map[cpu]} == remap_node) begin
          for (int i = 0; i < win_count; i++) begin
            offset = addr - win_base[i];
            if (!found && addr >= win_base[i] && offset < win_len[i]) begin
              r.address = win_repl[i] + offset;
              r.hit     = 1'b1;
              found     = 1;
            end
          end
        end
      end
      OP_REGISTER: begin
        if (addr == 0 || size == 0 || repl == 0) begin
          r.status = STATUS_BAD_WIN;
        end else if (win_count == MAX_WINDOWS) begin
          r.status = STATUS_FULL;
        end else begin
          win_base[win_count] = addr;
          win_len[win_count]  = size;
          win_repl[win_count] = repl;
          win_count++;
        end
      end
      OP_SET_NODE: begin
        cpu_map[cpu] = node;
      end
      default: ;
    endcase
    return r;
  endfunction

  // Push an expectation per accepted item, compare each accepted result
  always @(posedge clk) begin
    remap_result_t want;
    remap_result_t seen;
    if (rst) begin
      win_count  = 0;
      remap_node = '1;
      mismatches = 0;
      foreach (cpu_map[i]) cpu_map[i] = '0;
      awaited_results.delete();
    end else begin
      if (req.valid && req.ready) begin
        awaited_results.push_back(predict_remap(req.op, req.address, req.window_size,
                                                req.replica_base, req.cpu, req.cpu_node));
      end
      if (rsp.valid && rsp.ready) begin
        seen = {rsp.out_address, rsp.hit, rsp.status};
        if (awaited_results.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result: addr %h hit %b status %0d",
                   $time, seen.address, seen.hit, seen.status);
        end else begin
          want = awaited_results.pop_front();
          if (seen.address !== want.address || seen.hit !== want.hit ||
              seen.status !== want.status) begin
            mismatches++;
            $display("%0t: mismatch: expected addr %h hit %b status %0d, got addr %h hit %b status %0d",
                     $time, want.address, want.hit, want.status,
                     seen.address, seen.hit, seen.status);
          end
        end
      end
      if (cfg_we) remap_node = cfg_data;
    end
    outstanding = awaited_results.size();
  end

endmodule

// ===== tb/tb.sv =====
// Testbench top for the replica range remap block: stimulus, flow control and verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rrr_pkg::*;

  localparam int                WATCHDOG_LIMIT = 3000;
  localparam int                HOLD_CYCLES    = 80;
  localparam int                PHASE_ITEMS    = 79;
  localparam logic [ADDR_W-1:0] ADDR_MAX       = '1;
  // Operation code with no function
  localparam logic [OP_W-1:0]   OP_SPARE       = 2'd3;
  // Replica node per random phase; the last one is replaced by a random value
  localparam logic [6:0][REPL_NODE_W-1:0] NODE_PLAN =
    {7'd0, 7'd5, 7'h40, 7'd31, 7'h7F, 7'd63, 7'd0};

  typedef enum {RX_ALWAYS, RX_COIN, RX_PERIODIC, RX_SPARSE} rx_mode_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [REPL_NODE_W-1:0] cfg_data;
  int                     mismatches;
  int                     outstanding;

  rrr_in_if  req_ch ();
  rrr_out_if rsp_ch ();

  replica_range_remap uut (
    .clk      (clk),
    .rst      (rst),
    .req      (req_ch),
    .rsp      (rsp_ch),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  rrr_checker chk (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // Stimulus-side view of what was sent, used only to aim items
  logic [NODE_W-1:0]             node_sent [NUM_CPUS];
  logic [ADDR_W-1:0]             known_base [$];
  logic [ADDR_W-1:0]             known_len  [$];
  logic signed [REPL_NODE_W-1:0] active_node;
  bit                            req_up;
  int                            burst_left;
  int                            hold_seq = 0;
  int                            quiet = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [ADDR_W-1:0] rand_addr();
    logic [63:0] v;
    v = {$urandom(), $urandom()};
    return v[ADDR_W-1:0];
  endfunction

  // Offer one item, wait for it to be taken, then pace the sender in bursts
  task automatic offer(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
                       input logic [ADDR_W-1:0] size, input logic [ADDR_W-1:0] repl,
                       input logic [CPU_W-1:0] cpu, input logic [NODE_W-1:0] node);
    req_ch.valid        <= 1'b1;
    req_ch.op           <= op;
    req_ch.address      <= addr;
    req_ch.window_size  <= size;
    req_ch.replica_base <= repl;
    req_ch.cpu          <= cpu;
    req_ch.cpu_node     <= node;
    req_up = 1;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    if (op == OP_SET_NODE) node_sent[cpu] = node;
    if (op == OP_REGISTER && addr != 0 && size != 0 && repl != 0 &&
        known_base.size() < MAX_WINDOWS) begin
      known_base.push_back(addr);
      known_len.push_back(size);
    end
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 30);
      req_ch.valid <= 1'b0;
      req_up = 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Drop valid and wait until every item has produced its result
  task automatic drain();
    if (req_up) begin
      req_ch.valid <= 1'b0;
      req_up = 0;
    end
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_remap_node(input logic [REPL_NODE_W-1:0] v);
    drain();
    cfg_we   <= 1'b1;
    cfg_data <= v;
    active_node = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // One random item, mostly well-formed and aimed at registered windows
  task automatic random_item();
    logic [OP_W-1:0]   op;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] size;
    logic [ADDR_W-1:0] repl;
    logic [CPU_W-1:0]  cpu;
    logic [NODE_W-1:0] node;
    logic [63:0]       draw;
    int                pick;
    int                idx;
    addr = rand_addr();
    size = rand_addr();
    repl = rand_addr();
    cpu  = CPU_W'($urandom_range(0, NUM_CPUS - 1));
    node = NODE_W'($urandom_range(0, 63));
    draw = {$urandom(), $urandom()};
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      op = OP_TRANSLATE;
      idx = (known_base.size() > 0) ? $urandom_range(0, known_base.size() - 1) : 0;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: if (known_base.size() > 0)
          addr = known_base[idx] + ADDR_W'(draw % 64'(known_len[idx]));
        6: if (known_base.size() > 0)
          addr = draw[0] ? known_base[idx] + known_len[idx] : known_base[idx] - 1;
        7: addr = '0;
        default: ;
      endcase
      // Prefer a cpu that sits on the replica node
      if (!active_node[REPL_NODE_W-1] && $urandom_range(0, 4) != 0) begin
        repeat (16) begin
          if (node_sent[cpu] != active_node[NODE_W-1:0])
            cpu = CPU_W'($urandom_range(0, NUM_CPUS - 1));
        end
      end
    end else if (pick < 75) begin
      op = OP_REGISTER;
      if (draw[0]) addr = ADDR_W'($urandom_range(1, 65535));
      case ($urandom_range(0, 19))
        0: size = ADDR_MAX;
        1, 2, 3: size = rand_addr() >> $urandom_range(0, 40);
        default: size = ADDR_W'($urandom_range(1, 4096));
      endcase
      // Break a few windows with a zero field
      case ($urandom_range(0, 19))
        0: addr = '0;
        1: size = '0;
        2: repl = '0;
        default: ;
      endcase
    end else if (pick < 93) begin
      op = OP_SET_NODE;
      if (!active_node[REPL_NODE_W-1] && draw[1]) node = active_node[NODE_W-1:0];
    end else begin
      op = OP_SPARE;
    end
    offer(op, addr, size, repl, cpu, node);
  endtask

  // Result side: stall on its own pattern, with a long hold-off on request
  initial begin
    rx_mode_t mode;
    int       mode_left;
    int       hold_left;
    int       seen_seq;
    int       tick;
    bit       r;
    mode      = RX_ALWAYS;
    mode_left = 0;
    hold_left = 0;
    seen_seq  = 0;
    tick      = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      tick++;
      if (mode_left == 0) begin
        mode      = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      if (hold_seq != seen_seq) begin
        seen_seq  = hold_seq;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        r = 1'b0;
      end else begin
        case (mode)
          RX_ALWAYS:   r = 1'b1;
          RX_COIN:     r = 1'($urandom_range(0, 1));
          RX_PERIODIC: r = (tick % 5) != 0;
          default:     r = ($urandom_range(0, 7) == 0);
        endcase
      end
      rsp_ch.ready <= r;
    end
  end

  // Abort when nothing moves on either channel for too long
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet <= 0;
    end else if (quiet == WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    rst                 = 1'b1;
    cfg_we              = 1'b0;
    cfg_data            = '0;
    req_ch.valid        = 1'b0;
    req_ch.op           = OP_TRANSLATE;
    req_ch.address      = '0;
    req_ch.window_size  = '0;
    req_ch.replica_base = '0;
    req_ch.cpu          = '0;
    req_ch.cpu_node     = '0;
    foreach (node_sent[i]) node_sent[i] = '0;
    active_node = '1;
    req_up      = 0;
    burst_left  = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Empty table, unused op, broken windows
    offer(OP_TRANSLATE, 48'h1234, '0, '0, 8'd0, '0);
    offer(OP_SPARE, ADDR_MAX, ADDR_MAX, ADDR_MAX, 8'hFF, 6'h3F);
    offer(OP_REGISTER, '0, 48'h100, 48'h5000, 8'd0, '0);
    offer(OP_REGISTER, 48'h1000, '0, 48'h5000, 8'd0, '0);
    offer(OP_REGISTER, 48'h1000, 48'h100, '0, 8'd0, '0);
    // Overlapping windows, a window at the top and one whose replica wraps
    offer(OP_REGISTER, 48'h1000, 48'h100, 48'h8000_0000_0000, 8'd0, '0);
    offer(OP_REGISTER, 48'h1080, 48'h1000, 48'h1, 8'd0, '0);
    offer(OP_REGISTER, ADDR_MAX, 48'h1, ADDR_MAX, 8'd0, '0);
    offer(OP_REGISTER, 48'hFFFF_FFFF_F000, 48'h1000, 48'hFFFF_FFFF_FF00, 8'd0, '0);
    offer(OP_SET_NODE, '0, '0, '0, 8'd0, 6'd5);
    offer(OP_SET_NODE, '0, '0, '0, 8'd255, 6'd63);
    offer(OP_SET_NODE, '0, '0, '0, 8'd7, 6'd0);
    // Remapping disabled after reset
    offer(OP_TRANSLATE, 48'h1010, '0, '0, 8'd0, '0);
    set_remap_node(7'd5);
    offer(OP_TRANSLATE, 48'h1010, '0, '0, 8'd0, '0);
    offer(OP_TRANSLATE, 48'h10FF, '0, '0, 8'd0, '0);
    offer(OP_TRANSLATE, 48'h1100, '0, '0, 8'd0, '0);
    offer(OP_TRANSLATE, '0, '0, '0, 8'd0, '0);
    offer(OP_TRANSLATE, 48'h1010, '0, '0, 8'd255, '0);
    offer(OP_TRANSLATE, 48'hFFFF_FFFF_F800, '0, '0, 8'd0, '0);
    offer(OP_TRANSLATE, 48'h2080, '0, '0, 8'd0, '0);
    set_remap_node(7'd63);
    offer(OP_TRANSLATE, ADDR_MAX, '0, '0, 8'd255, '0);
    set_remap_node(7'h40);
    offer(OP_TRANSLATE, 48'h1010, '0, '0, 8'd255, '0);
    set_remap_node(7'd0);
    offer(OP_TRANSLATE, 48'h1010, '0, '0, 8'd7, '0);
    offer(OP_TRANSLATE, 48'h1010, '0, '0, 8'd200, '0);

    // Random phases, each under its own replica node
    for (int ph = 0; ph < 7; ph++) begin
      set_remap_node(ph == 6 ? REPL_NODE_W'($urandom_range(0, 127)) : NODE_PLAN[ph]);
      // Hold the result side off while the sender keeps offering items
      if (ph % 2 == 1) begin
        hold_seq <= hold_seq + 1;
        burst_left = 24;
      end
      repeat (PHASE_ITEMS) random_item();
    end

    drain();
    if (mismatches == 0 && outstanding == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/rrr_pkg.sv
sv/rrr_ifs.sv
sv/rrr_front.sv
sv/rrr_queue.sv
sv/rrr_back.sv
sv/replica_range_remap.sv
tb/rrr_checker.sv
tb/tb.sv
